// ===== src/kts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kts_pkg;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = $clog2(MaxKeys + 1);

  localparam logic [1:0] CfgKeyCount = 2'd0;
  localparam logic [1:0] CfgDuration = 2'd1;
  localparam logic [1:0] CfgLoop     = 2'd2;
  localparam logic [1:0] CfgStep     = 2'd3;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic       load_in;    // capture input beat
    logic       wr_key;     // store keyframe
    logic       clk_upd;    // start clock update
    logic       mod_step;   // one restoring step of clock modulo
    logic       clk_fin;    // commit clock
    logic       rd_key;     // issue read at search index
    logic       seg_chk;    // evaluate segment
    logic       idx_inc;    // advance search index
    logic       idx_clr;    // clear search index
    logic       div_init;   // start fraction divide
    logic       div_step;   // one divide step
    logic       rd_next;    // read upper key of segment
    logic       mul_go;     // register blend products
    logic       out_load;   // load result register
    logic       use_first;  // take key 0 as result
  } kts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic mod_need;   // clock wraps in loop mode with non-zero duration
    logic seg_hit;
    logic seg_zero;
    logic seg_last;   // no further segment to test
    logic early;      // single key or clock at/before key 0
  } kts_sts_t;

endpackage
`default_nettype wire

// ===== src/kts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kts_ctrl import kts_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  input  kts_sts_t sts_i,
  output kts_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StDec   = 12'b000000000010,
    StMod   = 12'b000000000100,
    StFin   = 12'b000000001000,
    StRd0   = 12'b000000010000,
    StEarly = 12'b000000100000,
    StRd    = 12'b000001000000,
    StChk   = 12'b000010000000,
    StDiv   = 12'b000100000000,
    StMul   = 12'b001000000000,
    StOut   = 12'b010000000000,
    StWait  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  assign out_valid = out_valid_q;
  assign in_ready  = (state_q == StIdle);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    if (out_valid_q && out_ready) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (!sts_i.is_tick) begin
          cmd_o.wr_key = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.clk_upd = 1'b1;
          cnt_d = '0;
          state_d = StMod;
        end
      end
      StMod: begin
        if (sts_i.mod_need) begin
          cmd_o.mod_step = 1'b1;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd32) state_d = StFin;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.clk_fin = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d = StRd0;
      end
      StRd0: begin
        cmd_o.rd_key = 1'b1;
        state_d = StEarly;
      end
      StEarly: begin
        // key 0 data now registered
        if (sts_i.early) begin
          cmd_o.use_first = 1'b1;
          state_d = StWait;
        end else begin
          cmd_o.rd_key = 1'b1;
          state_d = StRd;
        end
      end
      StRd: begin
        cmd_o.rd_next = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        cmd_o.seg_chk = 1'b1;
        if (sts_i.seg_hit) begin
          if (sts_i.seg_zero) begin
            state_d = StWait;
          end else begin
            cmd_o.div_init = 1'b1;
            cnt_d = '0;
            state_d = StDiv;
          end
        end else if (sts_i.seg_last) begin
          cmd_o.use_first = 1'b1;
          state_d = StWait;
        end else begin
          // upper key of this segment becomes the lower key of the next
          cmd_o.idx_inc = 1'b1;
          state_d = StRd;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd47) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_go = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        state_d = StWait;
      end
      StWait: begin
        if (!out_valid_q || out_ready) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/kts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kts_dp import kts_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [1:0]  cfg_idx_i,
  input  wire        [31:0] cfg_data_i,
  input  wire               req_type_i,
  input  wire  [IdxW-1:0]   key_index_i,
  input  wire        [31:0] key_time_i,
  input  wire signed [31:0] key_x_i,
  input  wire signed [31:0] key_y_i,
  input  wire signed [31:0] key_z_i,
  input  kts_cmd_t          cmd_i,
  output kts_sts_t          sts_o,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic       [31:0] anim_time_o,
  output logic              playing_o
);

  // configuration registers
  logic [6:0]  key_count_q;
  logic [31:0] duration_q, step_q;
  logic        loop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= 7'd1;
      duration_q <= 32'd65536;
      loop_q <= 1'b0;
      step_q <= 32'd1092;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyCount: key_count_q <= cfg_data_i[6:0];
        CfgDuration: duration_q <= cfg_data_i;
        CfgLoop:     loop_q <= cfg_data_i[0];
        CfgStep:     step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp key count to 1..MaxKeys
  logic [CntW-1:0] n_keys;
  always_comb begin
    if (key_count_q == 7'd0) n_keys = CntW'(1);
    else if (32'(key_count_q) > MaxKeys) n_keys = CntW'(MaxKeys);
    else n_keys = CntW'(key_count_q);
  end

  // input beat capture
  logic              req_q;
  logic [IdxW-1:0]   widx_q;
  logic [31:0]       wt_q;
  logic [95:0]       wv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_type_i;
      widx_q <= key_index_i;
      wt_q <= key_time_i;
      wv_q <= {key_z_i, key_y_i, key_x_i};
    end
  end

  // clock state and modulo by restoring subtraction
  logic [31:0] clk_q;
  logic        play_q;
  logic [32:0] sum_q;
  logic [31:0] rem_q;
  logic [32:0] sh_q;
  logic        wrap_q;
  logic [32:0] sum_w;
  logic [32:0] rtry;
  logic [32:0] rdif;
  assign sum_w = {1'b0, clk_q} + (play_q ? {1'b0, step_q} : 33'd0);
  assign rtry = {rem_q, sh_q[32]};
  assign rdif = rtry - {1'b0, duration_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q <= '0;
      play_q <= 1'b1;
    end else if (cmd_i.clk_fin) begin
      if (wrap_q) begin
        if (loop_q) clk_q <= (duration_q == 32'd0) ? 32'd0 : rem_q;
        else begin
          clk_q <= duration_q;
          play_q <= 1'b0;
        end
      end else begin
        clk_q <= sum_q[31:0];
      end
    end
  end
  // one dividend bit shifted into the remainder a step, 33 steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.clk_upd) begin
      sum_q <= sum_w;
      wrap_q <= sum_w >= {1'b0, duration_q};
      rem_q <= '0;
      sh_q <= sum_w;
    end else if (cmd_i.mod_step) begin
      if (rtry >= {1'b0, duration_q}) rem_q <= rdif[31:0];
      else rem_q <= rtry[31:0];
      sh_q <= {sh_q[31:0], 1'b0};
    end
  end

  // key memory
  logic [31:0] mt [MaxKeys];
  logic [95:0] mv [MaxKeys];
  logic [IdxW-1:0] idx_q;
  logic [31:0] rt_q;
  logic [95:0] rv_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_key) begin
      mt[widx_q] <= wt_q;
      mv[widx_q] <= wv_q;
    end
    if (cmd_i.rd_key || cmd_i.rd_next) begin
      rt_q <= mt[cmd_i.rd_next ? idx_q + IdxW'(1) : idx_q];
      rv_q <= mv[cmd_i.rd_next ? idx_q + IdxW'(1) : idx_q];
    end
  end

  // search index, lower key and key 0 holding
  logic [31:0] t0_q, k0t_q;
  logic [95:0] v0_q, k0v_q;
  logic first_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_clr) idx_q <= '0;
    else if (cmd_i.idx_inc) idx_q <= idx_q + IdxW'(1);
    if (cmd_i.idx_clr) first_q <= 1'b1;
    else if (cmd_i.rd_next) first_q <= 1'b0;
    if (cmd_i.rd_next) begin
      t0_q <= rt_q;
      v0_q <= rv_q;
      if (first_q) begin
        k0t_q <= rt_q;
        k0v_q <= rv_q;
      end
    end
  end

  logic seg_hit;
  assign seg_hit = (t0_q <= clk_q) && (clk_q <= rt_q);

  // fraction divide: (c - t0) << 16 over (t1 - t0), 48 quotient bits
  logic [31:0] dsr_q;
  logic [47:0] quo_q;
  logic [32:0] prem_q;
  logic [33:0] dsub;
  assign dsub = {prem_q, quo_q[47]} - {2'b0, dsr_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dsr_q <= rt_q - t0_q;
      quo_q <= {clk_q - t0_q, 16'd0};
      prem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!dsub[33]) begin
        prem_q <= dsub[32:0];
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        prem_q <= {prem_q[31:0], quo_q[47]};
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  // blend: a + floor((b - a) * frac / 65536), frac <= 65536
  logic [16:0] frac;
  assign frac = quo_q[16:0];
  logic signed [32:0] dlt [3];
  logic signed [50:0] prod_q [3];
  logic signed [95:0] res_w;
  logic [95:0] res_q;
  logic prod_done_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlt[k] = 33'(signed'(rv_q[32*k +: 32])) - 33'(signed'(v0_q[32*k +: 32]));
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      for (int k = 0; k < 3; k++) prod_q[k] <= 51'(dlt[k]) * 51'(signed'({1'b0, frac}));
    end
  end
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_w[32*k +: 32] = v0_q[32*k +: 32] + prod_q[k][47:16];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prod_done_q <= 1'b0;
    else prod_done_q <= cmd_i.mul_go;
  end
  // result: key 0 (straight after its read or held from the search), lower key on a hit, or blend
  always_ff @(posedge clk_i) begin
    if (cmd_i.use_first) res_q <= first_q ? rv_q : k0v_q;
    else if (cmd_i.seg_chk && seg_hit) res_q <= v0_q;
    else if (prod_done_q) res_q <= res_w;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      value_x_o <= res_q[31:0];
      value_y_o <= res_q[63:32];
      value_z_o <= res_q[95:64];
      anim_time_o <= clk_q;
      playing_o <= play_q;
    end
  end

  // status
  always_comb begin
    sts_o.is_tick = (req_q == ReqTick);
    sts_o.mod_need = wrap_q && loop_q && (duration_q != 32'd0);
    sts_o.seg_hit = seg_hit;
    sts_o.seg_zero = (rt_q == t0_q);
    sts_o.seg_last = (CntW'(idx_q) + CntW'(2)) >= n_keys;
    sts_o.early = (n_keys == CntW'(1)) || (clk_q <= rt_q);
  end

endmodule
`default_nettype wire

// ===== src/keyframe_track_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a key write is stored with no result; a tick updates the clock, then either takes key 0
// or tests segments in turn, and a hit of non-zero span runs the fraction divide and blend
// a looped clock that wraps first runs the serial modulo
// one beat at a time, the next taken the cycle after a key write or a result load
// reset: clock 0, playing 1, registers at defaults; key table undefined until written
module keyframe_track_sampler import kts_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [1:0]  cfg_idx_i,
  input  wire        [31:0] cfg_data_i,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               req_type_i,
  input  wire        [5:0]  key_index_i,
  input  wire        [31:0] key_time_i,
  input  wire signed [31:0] key_x_i,
  input  wire signed [31:0] key_y_i,
  input  wire signed [31:0] key_z_i,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic       [31:0] anim_time_o,
  output logic              playing_o
);

  kts_cmd_t cmd;
  kts_sts_t sts;

  kts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  kts_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .key_index_i(key_index_i[IdxW-1:0]), .key_time_i,
    .key_x_i, .key_y_i, .key_z_i,
    .cmd_i(cmd), .sts_o(sts),
    .value_x_o, .value_y_o, .value_z_o, .anim_time_o, .playing_o
  );

  // once stopped the track stays stopped
  a_play_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !playing_o |=> !(out_valid && playing_o))
    else $error("play flag set again");
  // no new beat accepted in the cycle the result is loaded
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(in_valid && in_ready))
    else $error("beat accepted during result load");

endmodule
`default_nettype wire
